FILE: hdl/lsf_pkg.sv
`timescale 1ns / 1ps

package lsf_pkg;

    localparam int LSF_LINE_MAX   = 63;
    localparam int LSF_BYTE_W     = 8;
    localparam int LSF_PAT_LANES  = 8;
    localparam int LSF_PAT_W      = LSF_PAT_LANES * LSF_BYTE_W;
    localparam int LSF_PLEN_W     = 4;
    localparam int LSF_LEN_W      = 7;
    localparam int LSF_WIN_CELLS  = LSF_PAT_LANES - 1;

    localparam logic [LSF_BYTE_W-1:0] LSF_NEWLINE = 8'd10;
    localparam logic [LSF_LEN_W-1:0]  LSF_LEN_SAT = 7'd127;

    // configuration register indexes
    localparam logic LSF_REG_PATTERN = 1'b0;
    localparam logic LSF_REG_PLEN    = 1'b1;

    typedef struct packed {
        logic [LSF_PAT_W-1:0]  pattern;
        logic [LSF_PLEN_W-1:0] plen;
    } lsf_cfg_t;

    // clamp the pattern length to 1..8
    function automatic logic [LSF_PLEN_W-1:0] lsf_eff_len(input logic [LSF_PLEN_W-1:0] l);
        logic [LSF_PLEN_W-1:0] r;
        r = l;
        if (l == '0) begin
            r = LSF_PLEN_W'(1);
        end else if (l > LSF_PLEN_W'(LSF_PAT_LANES)) begin
            r = LSF_PLEN_W'(LSF_PAT_LANES);
        end
        return r;
    endfunction

endpackage

FILE: hdl/lsf_cell.sv
`timescale 1ns / 1ps

module lsf_cell
    import lsf_pkg::*;
#(
    parameter int W = LSF_BYTE_W
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] data_reg;

    // one byte of the chain, loaded from its neighbor or from the input
    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;

endmodule

FILE: hdl/lsf_match.sv
`timescale 1ns / 1ps

module lsf_match
    import lsf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  shift_en,
    input  logic [LSF_BYTE_W-1:0] data_byte,
    input  lsf_cfg_t              cfg,
    input  logic [LSF_LEN_W-1:0]  line_len,
    output logic                  hit
);

    logic [LSF_BYTE_W-1:0]    win [LSF_WIN_CELLS];
    logic [LSF_BYTE_W-1:0]    cur [LSF_PAT_LANES];
    logic [LSF_PAT_LANES-1:0] lane_ok;
    logic [LSF_PLEN_W-1:0]    eff_len;
    logic [LSF_LEN_W:0]       seen;

    // window of recent bytes, newest in cell 0
    genvar g;
    generate
        for (g = 0; g < LSF_WIN_CELLS; g++) begin : g_win
            lsf_cell #(.W(LSF_BYTE_W)) u_cell (
                .aclk (aclk),
                .en   (shift_en),
                .din  (cur[g]),
                .dout (win[g])
            );
        end
    endgenerate

    // per-lane compare against the pattern, lanes beyond the length pass
    always_comb begin
        cur[0] = data_byte;
        for (int j = 1; j < LSF_PAT_LANES; j++) begin
            cur[j] = win[j-1];
        end
        eff_len = lsf_eff_len(cfg.plen);
        for (int j = 0; j < LSF_PAT_LANES; j++) begin
            lane_ok[j] = (cur[j] == cfg.pattern[j*LSF_BYTE_W +: LSF_BYTE_W]) ||
                         (LSF_PLEN_W'(j) >= eff_len);
        end
        seen = {1'b0, line_len} + (LSF_LEN_W+1)'(1);
        hit  = (&lane_ok) && (seen >= (LSF_LEN_W+1)'(eff_len));
    end

endmodule

FILE: hdl/line_substring_filter_top.sv
`timescale 1ns / 1ps
// channel   direction  tdata                      tlast          tuser
// s_axis    in         [7:0] data_byte            stream_end     -
// m_axis    out        [7:0] out_byte             line_last      [0] line_truncated
// cfg       in         index 0 pattern_bytes, index 1 pattern_length (write only)
//
// One input byte is taken per cycle while no line is being emitted.
// A matching line of n stored bytes (n up to LINE_MAX) is sent as n+1 output
// transactions, one per cycle from the shift chain of store cells; input waits.
// Reset is synchronous and clears control state only; the store needs no clearing.
// An output register holds each result, so m_tready low stalls emission in place.

module line_substring_filter_top
    import lsf_pkg::*;
#(
    parameter int LINE_MAX = LSF_LINE_MAX
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // cfg write port
    input  logic                  cfg_wr_en,
    input  logic                  cfg_addr,
    input  logic [LSF_PAT_W-1:0]  cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_byte
    output logic                  m_tlast,
    output logic [0:0]            m_tuser    // [0] line_truncated
);

    localparam int IDX_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int CNT_W = $clog2(LINE_MAX + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    lsf_cfg_t              cfg_reg, cfg_next;
    logic                  state_reg, state_next;
    logic [LSF_LEN_W-1:0]  len_reg, len_next;
    logic                  matched_reg, matched_next;
    logic                  ovf_reg, ovf_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  trunc_reg, trunc_next;
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            m_data_reg, m_data_next;
    logic                  m_last_reg, m_last_next;
    logic                  m_user_reg, m_user_next;

    logic                  in_acc;
    logic                  is_nl;
    logic                  close;
    logic                  hit;
    logic                  store_wr;
    logic                  out_load;
    logic                  line_hit;
    logic [LSF_LEN_W-1:0]  len_upd;
    logic [LSF_BYTE_W-1:0] cell_q [LINE_MAX];
    logic [LSF_BYTE_W-1:0] cell_d [LINE_MAX];
    logic [LINE_MAX-1:0]   cell_en;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign is_nl    = (s_tdata == LSF_NEWLINE);
    assign close    = in_acc && (is_nl || s_tlast);
    assign store_wr = in_acc && !is_nl && (len_reg < LSF_LEN_W'(LINE_MAX));
    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    // pattern window and compare
    lsf_match u_match (
        .aclk      (aclk),
        .shift_en  (in_acc && !is_nl),
        .data_byte (s_tdata),
        .cfg       (cfg_reg),
        .line_len  (len_reg),
        .hit       (hit)
    );

    // line store: written at the fill position, shifted toward cell 0 on emit
    genvar g;
    generate
        for (g = 0; g < LINE_MAX; g++) begin : g_store
            if (g == LINE_MAX - 1) begin : g_tail
                assign cell_d[g] = s_tdata;
            end else begin : g_body
                assign cell_d[g] = out_load ? cell_q[g+1] : s_tdata;
            end
            assign cell_en[g] = out_load ||
                                (store_wr && (len_reg[IDX_W-1:0] == IDX_W'(g)));
            lsf_cell #(.W(LSF_BYTE_W)) u_cell (
                .aclk (aclk),
                .en   (cell_en[g]),
                .din  (cell_d[g]),
                .dout (cell_q[g])
            );
        end
    endgenerate

    // configuration writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                LSF_REG_PATTERN: cfg_next.pattern = cfg_wdata;
                LSF_REG_PLEN:    cfg_next.plen    = cfg_wdata[LSF_PLEN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // line tracking and emission control
    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        matched_next = matched_reg;
        ovf_next     = ovf_reg;
        cnt_next     = cnt_reg;
        trunc_next   = trunc_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        len_upd      = len_reg;
        line_hit     = matched_reg;

        if (in_acc && !is_nl) begin
            line_hit = matched_reg || hit;
            if (len_reg < LSF_LEN_SAT) begin
                len_upd = len_reg + LSF_LEN_W'(1);
            end
        end

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && !is_nl) begin
                    len_next     = len_upd;
                    matched_next = line_hit;
                    if (!store_wr) begin
                        ovf_next = 1'b1;
                    end
                end
                if (close) begin
                    len_next     = '0;
                    matched_next = 1'b0;
                    ovf_next     = 1'b0;
                    if (line_hit) begin
                        state_next = ST_EMIT;
                        trunc_next = ovf_reg || (in_acc && !is_nl && !store_wr);
                        cnt_next   = (len_upd > LSF_LEN_W'(LINE_MAX)) ? CNT_W'(LINE_MAX)
                                                                        : CNT_W'(len_upd);
                    end
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_user_next  = trunc_reg;
                    if (cnt_reg != '0) begin
                        m_data_next = cell_q[0];
                        m_last_next = 1'b0;
                        cnt_next    = cnt_reg - CNT_W'(1);
                    end else begin
                        m_data_next = LSF_NEWLINE;
                        m_last_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern <= '0;
            cfg_reg.plen    <= LSF_PLEN_W'(1);
            state_reg       <= ST_IDLE;
            len_reg         <= '0;
            matched_reg     <= 1'b0;
            ovf_reg         <= 1'b0;
            cnt_reg         <= '0;
            trunc_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            state_reg   <= state_next;
            len_reg     <= len_next;
            matched_reg <= matched_next;
            ovf_reg     <= ovf_next;
            cnt_reg     <= cnt_next;
            trunc_reg   <= trunc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_user_reg;

    // a matching line close always starts emission
    a_close_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (close && line_hit) |=> (state_reg == ST_EMIT))
        else $error("matching line did not start emission");

    // the closing newline ends emission
    a_nl_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && cnt_reg == '0) |=> (state_reg == ST_IDLE && m_tlast && m_tvalid))
        else $error("emission did not end on the newline");

    // emit count never exceeds the store
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (cnt_reg <= CNT_W'(LINE_MAX)))
        else $error("emit count beyond the store");

    // no input taken while emitting
    a_no_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !in_acc)
        else $error("input accepted during emission");

    // an empty line never carries a match or overflow
    a_empty_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg == '0) |-> (!matched_reg && !ovf_reg))
        else $error("line state set on an empty line");

endmodule
